// File: rtl/max_rectangle_binary_image_macros.svh
// Assertion helpers shared by the RTL. Each use expands to one labeled
// concurrent assertion on the block clock, held off during reset.
`ifndef MAX_RECTANGLE_BINARY_IMAGE_MACROS_SVH
`define MAX_RECTANGLE_BINARY_IMAGE_MACROS_SVH

// Same-cycle implication.
`define MRBI_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("max rectangle assertion failed");

// Next-cycle implication.
`define MRBI_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("max rectangle assertion failed");

`endif

// File: rtl/mrbi_pkg.sv
`default_nettype none

package mrbi_pkg;

    // Image size limits.
    localparam int MAX_COLS = 1024;
    localparam int MAX_ROWS = 1024;

    // Widths derived from the limits.
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int H_W    = $clog2(MAX_ROWS + 1);
    localparam int CNT_W  = $clog2(MAX_COLS + 1);
    localparam int FW_W   = 11;
    localparam int AREA_W = 21;

    // Register reset value of the frame width.
    localparam logic [FW_W-1:0] FW_RESET = FW_W'(MAX_COLS);

    // One stack entry: column index and bar height.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [H_W-1:0]   hgt;
    } t_stack_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // latch an accepted pixel, start the height read
        logic hupd;      // update the column height store
        logic pop;       // pop the stack top and test its area
        logic push;      // push the current column
        logic next_col;  // advance to the next column
        logic row_done;  // close the row after the flush
        logic report;    // load the result register and clear the frame
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pop_req;   // stack top is taller than the current height
        logic row_end;   // current pixel closes its row
        logic last;      // current pixel ends the frame
        logic out_free;  // result register can take a new result
    } t_status;

endpackage

`default_nettype wire

// File: rtl/mrbi_ctrl.sv
`default_nettype none

module mrbi_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire mrbi_pkg::t_status i_status,
    output mrbi_pkg::t_cmd       o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_READ   = 5'b00010,
        S_SCAN   = 5'b00100,
        S_FLUSH  = 5'b01000,
        S_REPORT = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.hupd = 1'b1;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                if (i_status.pop_req) begin
                    o_cmd.pop = 1'b1;
                end else begin
                    o_cmd.push = 1'b1;
                    if (i_status.row_end) begin
                        n_state = S_FLUSH;
                    end else begin
                        o_cmd.next_col = 1'b1;
                        n_state        = S_IDLE;
                    end
                end
            end
            S_FLUSH: begin
                if (i_status.pop_req) begin
                    o_cmd.pop = 1'b1;
                end else begin
                    o_cmd.row_done = 1'b1;
                    n_state        = i_status.last ? S_REPORT : S_IDLE;
                end
            end
            S_REPORT: begin
                if (i_status.out_free) begin
                    o_cmd.report = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/mrbi_dp.sv
`default_nettype none

module mrbi_dp (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_valid,
    input  wire  [mrbi_pkg::FW_W-1:0]           i_cfg_frame_width,
    input  wire                                 i_pixel_set,
    input  wire                                 i_frame_last,
    input  wire mrbi_pkg::t_cmd                 i_cmd,
    output mrbi_pkg::t_status                   o_status,
    output logic                                o_valid,
    input  wire                                 i_ready,
    output logic [9:0]                          o_rect_x,
    output logic [9:0]                          o_rect_y,
    output logic [10:0]                         o_rect_width,
    output logic [10:0]                         o_rect_height,
    output logic [20:0]                         o_rect_area
);

    localparam int COL_W  = mrbi_pkg::COL_W;
    localparam int ROW_W  = mrbi_pkg::ROW_W;
    localparam int H_W    = mrbi_pkg::H_W;
    localparam int CNT_W  = mrbi_pkg::CNT_W;
    localparam int FW_W   = mrbi_pkg::FW_W;
    localparam int AREA_W = mrbi_pkg::AREA_W;

    // Frame width register and current pixel.
    logic [FW_W-1:0]  r_fw;
    logic             r_pix;
    logic             r_last;

    // Raster position.
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [CNT_W-1:0] r_prev_len;

    // Current bar height and the column it is tested against.
    logic [H_W-1:0]   r_cur_h;
    logic [CNT_W-1:0] r_pos;

    // Column height store.
    logic [H_W-1:0]   r_hmem [mrbi_pkg::MAX_COLS];
    logic [H_W-1:0]   r_hrd;

    // Stack: all entries in memory, the top also held in registers, and the
    // entry below the top prefetched every cycle.
    mrbi_pkg::t_stack_entry r_smem [mrbi_pkg::MAX_COLS];
    mrbi_pkg::t_stack_entry r_below;
    mrbi_pkg::t_stack_entry r_top;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [COL_W-1:0] s_rd_addr;

    // Candidate rectangle from the last pop.
    logic             r_cand_valid;
    logic [AREA_W-1:0] r_cand_area;
    logic [COL_W-1:0] r_cand_x;
    logic [ROW_W-1:0] r_cand_y;
    logic [CNT_W-1:0] r_cand_w;
    logic [H_W-1:0]   r_cand_h;

    // Best rectangle of the frame.
    logic [AREA_W-1:0] r_best_area;
    logic [COL_W-1:0] r_best_x;
    logic [ROW_W-1:0] r_best_y;
    logic [CNT_W-1:0] r_best_w;
    logic [H_W-1:0]   r_best_h;

    // Result register.
    logic             r_out_valid;

    logic [FW_W-1:0]  s_w_eff;
    logic [H_W-1:0]   s_old_h;
    logic [H_W-1:0]   s_new_h;
    logic [CNT_W-1:0] s_col_next;
    logic [CNT_W-1:0] s_left;
    logic [CNT_W-1:0] s_span;
    logic [2*H_W-1:0] s_prod;

    // Effective width: zero reads as one, large values saturate.
    always_comb begin
        if (r_fw == '0) begin
            s_w_eff = FW_W'(1);
        end else if (r_fw > FW_W'(mrbi_pkg::MAX_COLS)) begin
            s_w_eff = FW_W'(mrbi_pkg::MAX_COLS);
        end else begin
            s_w_eff = r_fw;
        end
    end

    assign s_col_next = CNT_W'(r_col) + CNT_W'(1);

    // New height of the current column; the first row and columns past the
    // previous row's end start from zero.
    always_comb begin
        if (r_row == '0 || CNT_W'(r_col) >= r_prev_len) begin
            s_old_h = '0;
        end else begin
            s_old_h = r_hrd;
        end
        if (!r_pix) begin
            s_new_h = '0;
        end else if (s_old_h >= H_W'(mrbi_pkg::MAX_ROWS)) begin
            s_new_h = H_W'(mrbi_pkg::MAX_ROWS);
        end else begin
            s_new_h = s_old_h + H_W'(1);
        end
    end

    // Area of the popped bar.
    assign s_left = (r_count >= CNT_W'(2)) ? CNT_W'(r_below.col) + CNT_W'(1) : '0;
    assign s_span = r_pos - s_left;
    assign s_prod = {{H_W{1'b0}}, r_top.hgt} * {{(2*H_W-CNT_W){1'b0}}, s_span};

    // Stack depth after this cycle, and prefetch of the entry below it.
    always_comb begin
        n_count = r_count;
        if (i_cmd.pop) begin
            n_count = r_count - CNT_W'(1);
        end else if (i_cmd.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.row_done) begin
            n_count = '0;
        end
    end
    assign s_rd_addr = n_count[COL_W-1:0] - COL_W'(2);

    // Status to the controller.
    assign o_status.pop_req  = (r_count != '0) && (r_top.hgt > r_cur_h);
    assign o_status.row_end  = (s_col_next >= CNT_W'(s_w_eff)) || r_last;
    assign o_status.last     = r_last;
    assign o_status.out_free = !r_out_valid || i_ready;

    // Column height store: registered read at the current column.
    always_ff @(posedge i_clk) begin
        if (i_cmd.hupd) begin
            r_hmem[r_col] <= s_new_h;
        end
        r_hrd <= r_hmem[r_col];
    end

    // Stack memory.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_smem[r_count[COL_W-1:0]] <= '{col: r_col, hgt: r_cur_h};
        end
        r_below <= r_smem[s_rd_addr];
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw <= mrbi_pkg::FW_RESET;
        end else if (i_cfg_valid) begin
            r_fw <= i_cfg_frame_width;
        end
    end

    // Pixel latch, current height and test position.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_pix  <= i_pixel_set;
            r_last <= i_frame_last;
            r_pos  <= CNT_W'(r_col);
        end
        if (i_cmd.hupd) begin
            r_cur_h <= s_new_h;
        end
        if (i_cmd.push) begin
            r_top <= '{col: r_col, hgt: r_cur_h};
            if (o_status.row_end) begin
                r_cur_h <= '0;
                r_pos   <= s_col_next;
            end
        end else if (i_cmd.pop) begin
            r_top <= r_below;
        end
    end

    // Stack depth and raster counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_prev_len <= '0;
        end else begin
            r_count <= n_count;
            if (i_cmd.next_col) begin
                r_col <= r_col + COL_W'(1);
            end
            if (i_cmd.row_done) begin
                r_col      <= '0;
                r_prev_len <= s_col_next;
                r_row      <= (r_row == ROW_W'(mrbi_pkg::MAX_ROWS - 1)) ? '0
                                                                       : r_row + ROW_W'(1);
            end
            if (i_cmd.report) begin
                r_row      <= '0;
                r_prev_len <= '0;
            end
        end
    end

    // Candidate register behind the multiplier.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand_valid <= 1'b0;
        end else begin
            r_cand_valid <= i_cmd.pop;
        end
        if (i_cmd.pop) begin
            r_cand_area <= s_prod[AREA_W-1:0];
            r_cand_x    <= s_left[COL_W-1:0];
            r_cand_y    <= r_row + ROW_W'(1) - r_top.hgt[ROW_W-1:0];
            r_cand_w    <= s_span;
            r_cand_h    <= r_top.hgt;
        end
    end

    // Best rectangle: only a strictly larger area replaces it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.report) begin
            r_best_area <= '0;
            r_best_x    <= '0;
            r_best_y    <= '0;
            r_best_w    <= '0;
            r_best_h    <= '0;
        end else if (r_cand_valid && r_cand_area > r_best_area) begin
            r_best_area <= r_cand_area;
            r_best_x    <= r_cand_x;
            r_best_y    <= r_cand_y;
            r_best_w    <= r_cand_w;
            r_best_h    <= r_cand_h;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.report) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (i_cmd.report) begin
            o_rect_x      <= 10'(r_best_x);
            o_rect_y      <= 10'(r_best_y);
            o_rect_width  <= 11'(r_best_w);
            o_rect_height <= 11'(r_best_h);
            o_rect_area   <= 21'(r_best_area);
        end
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// File: rtl/max_rectangle_binary_image.sv
// Channel   Signals                                  Direction  Transaction
// input     i_valid / o_ready, pixel fields          in         one pixel, raster order
// output    o_valid / i_ready, rectangle fields      out        best rectangle of a frame
// config    i_cfg_valid / o_cfg_ready, frame width   in         frame width write
//
// Each pixel is accepted, its height store is read, then it pops every stack entry
// taller than its height and is pushed; each entry is popped at most once per row.
// A row end pops every stack entry taller than zero, then closes the row.
// A frame end then loads the result register, which waits while a
// previous result is still held; no pixels are accepted while a result waits.
// Reset is synchronous; no clearing pass is needed after it.
`default_nettype none
`include "max_rectangle_binary_image_macros.svh"

module max_rectangle_binary_image (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [mrbi_pkg::FW_W-1:0]        i_cfg_frame_width,
    input  wire                              i_valid,
    output logic                             o_ready,
    input  wire                              i_pixel_set,
    input  wire                              i_frame_last,
    output logic                             o_valid,
    input  wire                              i_ready,
    output logic [9:0]                       o_rect_x,
    output logic [9:0]                       o_rect_y,
    output logic [10:0]                      o_rect_width,
    output logic [10:0]                      o_rect_height,
    output logic [20:0]                      o_rect_area
);

    mrbi_pkg::t_cmd    s_cmd;
    mrbi_pkg::t_status s_status;

    // Configuration is always taken.
    assign o_cfg_ready = 1'b1;

    // Controller.
    mrbi_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (s_status),
        .o_cmd    (s_cmd)
    );

    // Datapath with height store, stack and best rectangle.
    mrbi_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_frame_width (i_cfg_frame_width),
        .i_pixel_set       (i_pixel_set),
        .i_frame_last      (i_frame_last),
        .i_cmd             (s_cmd),
        .o_status          (s_status),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_rect_x          (o_rect_x),
        .o_rect_y          (o_rect_y),
        .o_rect_width      (o_rect_width),
        .o_rect_height     (o_rect_height),
        .o_rect_area       (o_rect_area)
    );

    // A pop is only issued when the stack top is taller than the current bar.
    `MRBI_ASSERT_IMP(a_pop_needed, s_cmd.pop, s_status.pop_req)
    // Push, pop and row close never coincide.
    `MRBI_ASSERT_IMP(a_one_stack_op, 1'b1, $onehot0({s_cmd.pop, s_cmd.push, s_cmd.row_done}))
    // After a pixel transaction the block is busy with it.
    `MRBI_ASSERT_NXT(a_busy_after_accept, i_valid && o_ready, !o_ready)
    // A report always lands in the result register.
    `MRBI_ASSERT_NXT(a_report_shown, s_cmd.report, o_valid)

endmodule

`default_nettype wire

// File: dv/tb_max_rectangle_binary_image.sv
`default_nettype none

module tb_max_rectangle_binary_image;

    // Cycles to let pass after the last rectangle before the block counts as idle.
    // A row flush can pop one stack entry per column, so the allowance scales with the column limit.
    localparam int SETTLE_CYCLES = 2 * mrbi_pkg::MAX_COLS + 16;
    localparam int RANDOM_PIXELS = 550;

    typedef struct packed {
        logic [9:0]  x;
        logic [9:0]  y;
        logic [10:0] w;
        logic [10:0] h;
        logic [20:0] area;
    } t_rect;

    // One row of the directed table: an optional frame width write, then one pixel.
    typedef struct packed {
        logic                      set_width;
        logic [mrbi_pkg::FW_W-1:0] width;
        logic                      pix;
        logic                      last;
        logic                      typed;
        t_rect                     want;
    } t_step;

    localparam t_rect NO_RECT = '0;
    localparam int N_STEPS = 26;
    localparam t_step STEPS [N_STEPS] = '{
        // Reset width: an empty frame, then a single set pixel.
        '{1'b0, 11'd0,    1'b0, 1'b1, 1'b1, NO_RECT},
        '{1'b0, 11'd0,    1'b1, 1'b1, 1'b1, '{10'd0, 10'd0, 11'd1, 11'd1, 21'd1}},
        // Width 3, two full rows.
        '{1'b1, 11'd3,    1'b1, 1'b0, 1'b0, NO_RECT},
        '{1'b0, 11'd0,    1'b1, 1'b0, 1'b0, NO_RECT},
        '{1'b0, 11'd0,    1'b1, 1'b0, 1'b0, NO_RECT},
        '{1'b0, 11'd0,    1'b1, 1'b0, 1'b0, NO_RECT},
        '{1'b0, 11'd0,    1'b1, 1'b0, 1'b0, NO_RECT},
        '{1'b0, 11'd0,    1'b1, 1'b1, 1'b1, '{10'd0, 10'd0, 11'd3, 11'd2, 21'd6}},
        // Width 4, frame ends in the middle of the first row.
        '{1'b1, 11'd4,    1'b1, 1'b0, 1'b0, NO_RECT},
        '{1'b0, 11'd0,    1'b1, 1'b1, 1'b1, '{10'd0, 10'd0, 11'd2, 11'd1, 21'd2}},
        // Width 4, a later rectangle of equal area must not replace the first.
        '{1'b0, 11'd0,    1'b1, 1'b0, 1'b0, NO_RECT},
        '{1'b0, 11'd0,    1'b1, 1'b0, 1'b0, NO_RECT},
        '{1'b0, 11'd0,    1'b0, 1'b0, 1'b0, NO_RECT},
        '{1'b0, 11'd0,    1'b1, 1'b0, 1'b0, NO_RECT},
        '{1'b0, 11'd0,    1'b0, 1'b0, 1'b0, NO_RECT},
        '{1'b0, 11'd0,    1'b0, 1'b0, 1'b0, NO_RECT},
        '{1'b0, 11'd0,    1'b1, 1'b0, 1'b0, NO_RECT},
        '{1'b0, 11'd0,    1'b1, 1'b1, 1'b1, '{10'd0, 10'd0, 11'd2, 11'd1, 21'd2}},
        // Width 1, a column that starts on the second row.
        '{1'b1, 11'd1,    1'b0, 1'b0, 1'b0, NO_RECT},
        '{1'b0, 11'd0,    1'b1, 1'b0, 1'b0, NO_RECT},
        '{1'b0, 11'd0,    1'b1, 1'b1, 1'b1, '{10'd0, 10'd1, 11'd1, 11'd2, 21'd2}},
        // Largest legal width.
        '{1'b1, 11'd1024, 1'b1, 1'b1, 1'b1, '{10'd0, 10'd0, 11'd1, 11'd1, 21'd1}},
        // Oversized width saturates.
        '{1'b1, 11'd2047, 1'b0, 1'b0, 1'b0, NO_RECT},
        '{1'b0, 11'd0,    1'b1, 1'b1, 1'b1, '{10'd1, 10'd0, 11'd1, 11'd1, 21'd1}},
        // Zero width acts as one column.
        '{1'b1, 11'd0,    1'b1, 1'b0, 1'b0, NO_RECT},
        '{1'b0, 11'd0,    1'b1, 1'b1, 1'b1, '{10'd0, 10'd0, 11'd1, 11'd2, 21'd2}}
    };

    // Block inputs, all known from time zero.
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_valid = 1'b0;
    logic [mrbi_pkg::FW_W-1:0] i_cfg_frame_width = '0;
    logic                      i_valid = 1'b0;
    logic                      i_pixel_set = 1'b0;
    logic                      i_frame_last = 1'b0;
    logic                      i_ready = 1'b0;

    wire             o_cfg_ready;
    wire             o_ready;
    wire             o_valid;
    wire [9:0]       o_rect_x;
    wire [9:0]       o_rect_y;
    wire [10:0]      o_rect_width;
    wire [10:0]      o_rect_height;
    wire [20:0]      o_rect_area;

    max_rectangle_binary_image dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_frame_width (i_cfg_frame_width),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_pixel_set       (i_pixel_set),
        .i_frame_last      (i_frame_last),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_rect_x          (o_rect_x),
        .o_rect_y          (o_rect_y),
        .o_rect_width      (o_rect_width),
        .o_rect_height     (o_rect_height),
        .o_rect_area       (o_rect_area)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Histogram tracker state, mirroring the block's frame state.
    logic [mrbi_pkg::FW_W-1:0]  width_reg;
    logic [mrbi_pkg::H_W-1:0]   col_hgt [mrbi_pkg::MAX_COLS];
    logic [mrbi_pkg::COL_W-1:0] bar_col [mrbi_pkg::MAX_COLS+1];
    logic [mrbi_pkg::H_W-1:0]   bar_hgt [mrbi_pkg::MAX_COLS+1];
    int unsigned      bar_count;
    int unsigned      col_pos;
    int unsigned      row_pos;
    int unsigned      prev_len;
    int unsigned      best_area;
    t_rect            best_rect;

    // Rectangles still owed by the block, oldest first.
    t_rect rects_due [$];

    // Typed expectation for the current directed row.
    logic  typed_valid = 1'b0;
    t_rect typed_rect = '0;

    // Handshake flags, set at the rising edge and read by the driver at the falling edge.
    logic pix_taken = 1'b0;
    logic cfg_taken = 1'b0;

    int unsigned mismatches = 0;
    int unsigned pixels_taken = 0;
    int unsigned rects_checked = 0;
    int unsigned width_writes = 0;
    int          burst_left = 0;
    logic [9:0]  stall_tick = '0;

    function automatic void clear_frame();
        bar_count = 0;
        col_pos   = 0;
        row_pos   = 0;
        prev_len  = 0;
        best_area = 0;
        best_rect = '0;
    endfunction

    // Pop every bar taller than hgt and keep the first strictly larger area.
    function automatic void pop_taller_bars(int unsigned pos, int unsigned hgt);
        int unsigned hh, left, span, area;
        while (bar_count > 0 && bar_hgt[bar_count-1] > hgt) begin
            hh = bar_hgt[bar_count-1];
            bar_count--;
            left = (bar_count != 0) ? bar_col[bar_count-1] + 1 : 0;
            span = pos - left;
            area = hh * span;
            if (area > best_area) begin
                best_area   = area;
                best_rect.x = 10'(left);
                best_rect.y = 10'(row_pos + 1 - hh);
                best_rect.w = 11'(span);
                best_rect.h = 11'(hh);
            end
        end
    endfunction

    // Advance the tracker by one pixel; returns 1 with the rectangle on a frame end.
    function automatic logic scan_pixel(input logic pix, input logic last, output t_rect rect);
        int unsigned w, c, old, h;
        w = width_reg;
        if (w == 0) w = 1;
        if (w > mrbi_pkg::MAX_COLS) w = mrbi_pkg::MAX_COLS;
        c = col_pos;
        if (c >= mrbi_pkg::MAX_COLS) c = mrbi_pkg::MAX_COLS - 1;
        old = (row_pos == 0 || c >= prev_len) ? 0 : col_hgt[c];
        h = pix ? old + 1 : 0;
        if (h > mrbi_pkg::MAX_ROWS) h = mrbi_pkg::MAX_ROWS;
        col_hgt[c] = mrbi_pkg::H_W'(h);
        pop_taller_bars(c, h);
        if (bar_count < mrbi_pkg::MAX_COLS + 1) begin
            bar_col[bar_count] = mrbi_pkg::COL_W'(c);
            bar_hgt[bar_count] = mrbi_pkg::H_W'(h);
            bar_count++;
        end
        // Row end: flush the stack with a zero-height bar.
        if (c + 1 >= w || last) begin
            pop_taller_bars(c + 1, 0);
            bar_count = 0;
            prev_len  = c + 1;
            col_pos   = 0;
            row_pos   = (row_pos + 1 >= mrbi_pkg::MAX_ROWS) ? 0 : row_pos + 1;
        end else begin
            col_pos = c + 1;
        end
        rect = '0;
        if (!last) return 1'b0;
        rect = best_rect;
        rect.area = 21'(best_area);
        clear_frame();
        return 1'b1;
    endfunction

    function automatic void note_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    task automatic check_rect();
        t_rect got, want;
        got = {o_rect_x, o_rect_y, o_rect_width, o_rect_height, o_rect_area};
        if (rects_due.size() == 0) begin
            $display("%0t: rectangle with none expected, actual x=%0d y=%0d w=%0d h=%0d area=%0d",
                     $time, got.x, got.y, got.w, got.h, got.area);
            mismatches++;
        end else begin
            want = rects_due.pop_front();
            rects_checked++;
            note_field("rect_x", want.x, got.x);
            note_field("rect_y", want.y, got.y);
            note_field("rect_width", want.w, got.w);
            note_field("rect_height", want.h, got.h);
            note_field("rect_area", want.area, got.area);
        end
    endtask

    // Watch all three channels at the rising edge.
    always @(posedge i_clk) begin : watch
        t_rect due;
        pix_taken = 1'b0;
        cfg_taken = 1'b0;
        if (i_rst_n) begin
            if (o_valid && i_ready) check_rect();
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_taken = 1'b1;
                width_reg = i_cfg_frame_width;
                width_writes++;
            end
            if (i_valid && o_ready) begin
                pix_taken = 1'b1;
                pixels_taken++;
                if (scan_pixel(i_pixel_set, i_frame_last, due))
                    rects_due.insert(rects_due.size(), typed_valid ? typed_rect : due);
            end
        end
    end

    // Result receiver stalls on a pattern chosen by bits 8:7 of a free-running tick counter.
    always @(negedge i_clk) begin
        stall_tick <= stall_tick + 1'b1;
        case (stall_tick[8:7])
            2'd0:    i_ready <= 1'b1;
            2'd1:    i_ready <= 1'($urandom_range(0, 1));
            2'd2:    i_ready <= ($urandom_range(0, 3) == 0);
            default: i_ready <= stall_tick[2];
        endcase
    end

    // Send one pixel transaction, in bursts separated by random gaps.
    task automatic send_pixel(input logic pix, input logic last);
        if (burst_left == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        i_valid      <= 1'b1;
        i_pixel_set  <= pix;
        i_frame_last <= last;
        do @(negedge i_clk); while (!pix_taken);
    endtask

    // Density is in sixteenths; a marked tail forces the final pixel set.
    task automatic send_frame(int unsigned len, int unsigned dens, logic with_last,
                              logic mark_tail);
        logic pix;
        for (int unsigned n = 0; n < len; n++) begin
            pix = ($urandom_range(0, 15) < dens);
            if (n == len - 1 && mark_tail) pix = 1'b1;
            send_pixel(pix, with_last && (n == len - 1));
        end
    endtask

    // Stop sending until every owed rectangle has arrived, optionally letting
    // the block finish any row flush that produces no rectangle.
    task automatic hold_until_idle(input logic settle);
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (rects_due.size() != 0) @(negedge i_clk);
        if (settle) repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_width(input logic [mrbi_pkg::FW_W-1:0] value);
        i_cfg_valid       <= 1'b1;
        i_cfg_frame_width <= value;
        do @(negedge i_clk); while (!cfg_taken);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int unsigned w, w_eff, frames, rows, len, dens, random_pixels, pick;
        logic finish_frame;
        width_reg = mrbi_pkg::FW_RESET;
        clear_frame();
        random_pixels = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table.
        foreach (STEPS[k]) begin
            if (STEPS[k].set_width) begin
                hold_until_idle(1'b1);
                write_width(STEPS[k].width);
            end
            typed_valid = STEPS[k].typed;
            typed_rect  = STEPS[k].want;
            send_pixel(STEPS[k].pix, STEPS[k].last);
            typed_valid = 1'b0;
        end

        // One column over more rows than the row counter holds; the column
        // height must restart once the counter wraps.
        hold_until_idle(1'b1);
        write_width(11'd1);
        for (int unsigned n = 0; n < mrbi_pkg::MAX_ROWS + 6; n++)
            send_pixel(n == mrbi_pkg::MAX_ROWS - 1 || n == mrbi_pkg::MAX_ROWS,
                       n == mrbi_pkg::MAX_ROWS + 5);

        // Random phases, each with its own frame width.
        while (random_pixels < RANDOM_PIXELS) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) w = $urandom_range(0, 12);
            else if (pick < 9) w = $urandom_range(13, 64);
            else w = $urandom_range(65, 2047);
            hold_until_idle(1'b1);
            write_width(mrbi_pkg::FW_W'(w));
            w_eff = (w == 0) ? 1 : ((w > mrbi_pkg::MAX_COLS) ? mrbi_pkg::MAX_COLS : w);
            frames = $urandom_range(1, 4);
            for (int f = 0; f < frames; f++) begin
                if (w_eff > 64) begin
                    len = $urandom_range(1, (w_eff > 200) ? 200 : w_eff);
                end else begin
                    rows = $urandom_range(1, 6);
                    len = rows * w_eff;
                    if ($urandom_range(0, 3) == 0) len = len - $urandom_range(0, w_eff - 1);
                end
                case ($urandom_range(0, 5))
                    0:       dens = 0;
                    1:       dens = 16;
                    default: dens = $urandom_range(4, 15);
                endcase
                // The last frame of a phase is sometimes left open, so the next
                // width write lands in the middle of a frame.
                finish_frame = (f < frames - 1) || ($urandom_range(0, 5) != 0);
                send_frame(len, dens, finish_frame, (dens == 0) || ($urandom_range(0, 7) == 0));
                random_pixels += len;
                if ($urandom_range(0, 3) == 0) hold_until_idle(1'b0);
            end
        end

        hold_until_idle(1'b1);
        $display("run covered %0d pixels, %0d rectangles checked, %0d frame width writes",
                 pixels_taken, rects_checked, width_writes);
        $display("including zero and oversized widths, early frame ends, "
                 , "a row counter wrap and width changes inside a frame");
        if (mismatches == 0 && rects_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Hard stop well beyond the longest legal run.
    initial begin
        #10_000_000;
        $display("timeout with %0d rectangles still owed", rects_due.size());
        $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
